// ----- rtl/core/flsfo_pkg.sv -----
// Shared types, codes and constants of the first-layer speed and fan override block.
package flsfo_pkg;

    // Default depth of the comment buffer in bytes
    localparam int COMMENT_BYTES_DEFAULT = 32;

    // Configuration port geometry
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Feed percentage outside the early layers
    localparam logic [9:0] FEED_FULL = 10'd100;

    // Configuration reset values
    localparam logic       FEATURE_ENABLE_RESET     = 1'b1;
    localparam logic [7:0] EARLY_LAYER_COUNT_RESET  = 8'd2;
    localparam logic [9:0] EARLY_FEED_PERCENT_RESET = 10'd50;
    localparam logic [7:0] EARLY_FAN_SPEED_RESET    = 8'd0;
    localparam logic [15:0] Z_STEP_THRESHOLD_RESET  = 16'd50;

    // Event codes
    typedef enum logic [3:0] {
        OP_START         = 4'd0,
        OP_END           = 4'd1,
        OP_COMMENT_BEGIN = 4'd2,
        OP_COMMENT_BYTE  = 4'd3,
        OP_COMMENT_END   = 4'd4,
        OP_LAYER_MARKER  = 4'd5,
        OP_EXTRUSION     = 4'd6,
        OP_FAN_REQUEST   = 4'd7,
        OP_SPEED_REQUEST = 4'd8
    } op_t;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FEATURE_ENABLE     = 3'd0,
        REG_EARLY_LAYER_COUNT  = 3'd1,
        REG_EARLY_FEED_PERCENT = 3'd2,
        REG_EARLY_FAN_SPEED    = 3'd3,
        REG_Z_STEP_THRESHOLD   = 3'd4
    } cfg_reg_t;

    // One input word
    typedef struct packed {
        logic [3:0]         operation;
        logic [7:0]         char_code;
        logic signed [15:0] layer_value;
        logic [23:0]        z_height;
        logic [2:0]         fan_index;
        logic [9:0]         request_value;
    } in_item_t;

    // One result word
    typedef struct packed {
        logic [9:0]         feed_percent;
        logic               fan_write;
        logic [7:0]         fan_value;
        logic               early_active;
        logic signed [15:0] answer;
    } out_item_t;

    // Clamp a request to a fan PWM value
    function automatic logic [7:0] sat_fan(input logic [9:0] req);
        return (req > 10'd255) ? 8'hFF : req[7:0];
    endfunction

    // Letters of the "LAYER:" prefix
    function automatic logic [7:0] colon_char(input logic [3:0] pos);
        logic [7:0] ch;
        case (pos)
            4'd0:    ch = "L";
            4'd1:    ch = "A";
            4'd2:    ch = "Y";
            4'd3:    ch = "E";
            4'd4:    ch = "R";
            4'd5:    ch = ":";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Letters of the twelve-letter layer-step tag
    function automatic logic [7:0] change_char(input logic [3:0] pos);
        logic [7:0] ch;
        case (pos)
            4'd0:    ch = "L";
            4'd1:    ch = "A";
            4'd2:    ch = "Y";
            4'd3:    ch = "E";
            4'd4:    ch = "R";
            4'd5:    ch = "_";
            4'd6:    ch = "C";
            4'd7:    ch = "H";
            4'd8:    ch = "A";
            4'd9:    ch = "N";
            4'd10:   ch = "G";
            4'd11:   ch = "E";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// ----- rtl/core/flsfo_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module flsfo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry and register one read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/first_layer_speed_fan_override.sv -----
// Top level of the first-layer feed and fan override block.
//
// Follows the layer being printed from layer markers or, until a marker is
// seen, from rising extrusion Z, and while the layer number is below
// early_layer_count it forces early_feed_percent and the fan 0 PWM
// early_fan_speed; leaving the early layers restores 100 percent feed and
// the last requested fan 0 speed. "LAYER:n" and layer-step tag comments are
// parsed and the layer number, or all ones, is given as the answer; they do
// not move the override. One word is taken at a time. Every event except
// comment end captures its result in the result register on acceptance; the
// result moves to the output register when that is free, and the input
// takes the next word after it has. Comment end steps through the buffered
// bytes one per cycle: the parser reads the comment buffer RAM one byte per
// cycle and folds each digit through a single shift-and-add multiply-by-ten
// unit. It stops on the byte that settles the answer, or at the position
// just past the last buffered byte, and then hands its result on in the
// same way. The buffer holds at most COMMENT_BYTES - 1 bytes. An accepted
// word is processed while an earlier result still waits in the output
// register; the new result then waits, and the input stalls, until the
// word ahead is taken.
module first_layer_speed_fan_override #(
    parameter int COMMENT_BYTES = flsfo_pkg::COMMENT_BYTES_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  flsfo_pkg::in_item_t                  in_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output flsfo_pkg::out_item_t                 out_data,
    input  logic                                 cfg_we,
    input  logic [flsfo_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [flsfo_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import flsfo_pkg::*;

    localparam int IW = $clog2(COMMENT_BYTES);
    localparam logic [IW-1:0] LEN_MAX = IW'(COMMENT_BYTES - 1);
    localparam logic [IW-1:0] COLON_LAST = IW'(5);
    localparam logic [IW-1:0] CHANGE_LAST = IW'(11);
    localparam logic [IW-1:0] COLON_LEN = IW'(6);
    localparam logic [IW-1:0] CHANGE_LEN = IW'(12);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    // Configuration
    logic        feature_enable_reg, feature_enable_next;
    logic [7:0]  early_layer_count_reg, early_layer_count_next;
    logic [9:0]  early_feed_percent_reg, early_feed_percent_next;
    logic [7:0]  early_fan_speed_reg, early_fan_speed_next;
    logic [15:0] z_step_threshold_reg, z_step_threshold_next;

    // Print tracking state
    logic        print_active_reg, print_active_next;
    logic        early_flag_reg, early_flag_next;
    logic        marker_seen_reg, marker_seen_next;
    logic        have_z_reg, have_z_next;
    logic [15:0] tracked_layer_reg, tracked_layer_next;
    logic [15:0] parsed_layer_reg, parsed_layer_next;
    logic [IW-1:0] comment_len_reg, comment_len_next;
    logic [7:0]  saved_fan_reg, saved_fan_next;
    logic [23:0] last_z_reg, last_z_next;
    logic [9:0]  feed_register_reg, feed_register_next;

    // Comment parser
    logic [IW-1:0] idx_reg, idx_next;
    logic [15:0]   acc_reg, acc_next;
    logic          found_reg, found_next;
    logic          digits_reg, digits_next;
    logic          colon_ok_reg, colon_ok_next;
    logic          change_ok_reg, change_ok_next;

    // Result and output stage
    out_item_t     res_reg, res_next;
    out_item_t     out_reg, out_next;
    logic          out_valid_reg, out_valid_next;

    // Comment buffer port
    logic          ram_we;
    logic [IW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    // Event scratch
    logic          apply_en;
    logic [15:0]   apply_lay;
    logic          apply_early;
    logic          fan_wr;
    logic [7:0]    fan_val;
    logic [15:0]   answer;
    logic          load_simple;
    logic          override_on;
    logic [24:0]   z_limit;
    logic          at_end;
    logic          is_digit;
    logic          c_hit;
    logic          g_hit;
    logic [15:0]   acc_times_ten;

    flsfo_ram #(
        .WIDTH (8),
        .DEPTH (COMMENT_BYTES)
    ) u_comment_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (comment_len_reg),
        .wdata (in_data.char_code),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Prefetch the next buffered byte while scanning; byte 0 while idle
    assign ram_raddr = (state_reg == S_SCAN && idx_reg != comment_len_reg)
                       ? idx_reg + IW'(1) : '0;

    // Shared parser arithmetic: byte tests and multiply-by-ten accumulate
    assign at_end   = (idx_reg == comment_len_reg);
    assign is_digit = (ram_rdata >= "0") && (ram_rdata <= "9");
    assign c_hit    = colon_ok_reg && (idx_reg < COLON_LEN)
                      && (ram_rdata == colon_char(idx_reg[3:0]));
    assign g_hit    = change_ok_reg && (idx_reg < CHANGE_LEN)
                      && (ram_rdata == change_char(idx_reg[3:0]));
    assign acc_times_ten = (acc_reg << 3) + (acc_reg << 1)
                           + {12'd0, ram_rdata[3:0]};

    assign override_on = print_active_reg & feature_enable_reg & early_flag_reg;
    assign z_limit     = {1'b0, last_z_reg} + {9'd0, z_step_threshold_reg};
    assign apply_early = $signed(apply_lay) < $signed({8'd0, early_layer_count_reg});

    always_comb
    begin
        state_next              = state_reg;
        feature_enable_next     = feature_enable_reg;
        early_layer_count_next  = early_layer_count_reg;
        early_feed_percent_next = early_feed_percent_reg;
        early_fan_speed_next    = early_fan_speed_reg;
        z_step_threshold_next   = z_step_threshold_reg;
        print_active_next       = print_active_reg;
        early_flag_next         = early_flag_reg;
        marker_seen_next        = marker_seen_reg;
        have_z_next             = have_z_reg;
        tracked_layer_next      = tracked_layer_reg;
        parsed_layer_next       = parsed_layer_reg;
        comment_len_next        = comment_len_reg;
        saved_fan_next          = saved_fan_reg;
        last_z_next             = last_z_reg;
        feed_register_next      = feed_register_reg;
        idx_next                = idx_reg;
        acc_next                = acc_reg;
        found_next              = found_reg;
        digits_next             = digits_reg;
        colon_ok_next           = colon_ok_reg;
        change_ok_next          = change_ok_reg;
        res_next                = res_reg;
        out_next                = out_reg;
        out_valid_next          = out_valid_reg;
        ram_we                  = 1'b0;
        apply_en                = 1'b0;
        apply_lay               = '0;
        fan_wr                  = 1'b0;
        fan_val                 = '0;
        answer                  = '0;
        load_simple             = 1'b0;

        // Write configuration
        if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_FEATURE_ENABLE:     feature_enable_next     = cfg_data[0];
                REG_EARLY_LAYER_COUNT:  early_layer_count_next  = cfg_data[7:0];
                REG_EARLY_FEED_PERCENT: early_feed_percent_next = cfg_data[9:0];
                REG_EARLY_FAN_SPEED:    early_fan_speed_next    = cfg_data[7:0];
                REG_Z_STEP_THRESHOLD:   z_step_threshold_next   = cfg_data;
                default: ;
            endcase
        end

        // Drop the output word once taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next  = S_DONE;
                    load_simple = 1'b1;
                    case (op_t'(in_data.operation))
                        OP_START:
                        begin
                            if (!print_active_reg)
                            begin
                                print_active_next  = 1'b1;
                                early_flag_next    = 1'b0;
                                marker_seen_next   = 1'b0;
                                have_z_next        = 1'b0;
                                tracked_layer_next = 16'hFFFF;
                                parsed_layer_next  = 16'hFFFF;
                                comment_len_next   = '0;
                                saved_fan_next     = sat_fan(in_data.request_value);
                            end
                        end
                        OP_END:
                        begin
                            if (early_flag_reg)
                            begin
                                fan_wr  = 1'b1;
                                fan_val = saved_fan_reg;
                            end
                            feed_register_next = FEED_FULL;
                            print_active_next  = 1'b0;
                            early_flag_next    = 1'b0;
                        end
                        OP_COMMENT_BEGIN:
                        begin
                            comment_len_next = '0;
                        end
                        OP_COMMENT_BYTE:
                        begin
                            if (comment_len_reg < LEN_MAX)
                            begin
                                ram_we           = 1'b1;
                                comment_len_next = comment_len_reg + IW'(1);
                            end
                        end
                        OP_COMMENT_END:
                        begin
                            state_next     = S_SCAN;
                            load_simple    = 1'b0;
                            idx_next       = '0;
                            acc_next       = '0;
                            found_next     = 1'b0;
                            digits_next    = 1'b0;
                            colon_ok_next  = 1'b1;
                            change_ok_next = 1'b1;
                        end
                        OP_LAYER_MARKER:
                        begin
                            marker_seen_next   = 1'b1;
                            tracked_layer_next = in_data.layer_value;
                            apply_en           = 1'b1;
                            apply_lay          = in_data.layer_value;
                        end
                        OP_EXTRUSION:
                        begin
                            if (print_active_reg && !marker_seen_reg)
                            begin
                                if (!have_z_reg)
                                begin
                                    have_z_next        = 1'b1;
                                    last_z_next        = in_data.z_height;
                                    tracked_layer_next = '0;
                                    apply_en           = 1'b1;
                                    apply_lay          = '0;
                                end
                                else if ({1'b0, in_data.z_height} > z_limit)
                                begin
                                    last_z_next        = in_data.z_height;
                                    tracked_layer_next = tracked_layer_reg + 16'd1;
                                    apply_en           = 1'b1;
                                    apply_lay          = tracked_layer_reg + 16'd1;
                                end
                            end
                        end
                        OP_FAN_REQUEST:
                        begin
                            if (print_active_reg && in_data.fan_index == 3'd0)
                            begin
                                saved_fan_next = sat_fan(in_data.request_value);
                            end
                            if (override_on && in_data.fan_index == 3'd0)
                            begin
                                answer = {8'd0, early_fan_speed_reg};
                            end
                            else
                            begin
                                answer = {8'd0, sat_fan(in_data.request_value)};
                            end
                        end
                        OP_SPEED_REQUEST:
                        begin
                            answer = override_on ? {6'd0, early_feed_percent_reg}
                                                 : {6'd0, in_data.request_value};
                        end
                        default: ;
                    endcase
                end
            end

            S_SCAN:
            begin
                if (digits_reg)
                begin
                    // Fold one digit, or close the number
                    if (at_end || !is_digit)
                    begin
                        state_next = S_DONE;
                        if (found_reg)
                        begin
                            parsed_layer_next = acc_reg;
                            res_next.answer   = acc_reg;
                        end
                        else
                        begin
                            res_next.answer = 16'hFFFF;
                        end
                    end
                    else
                    begin
                        acc_next   = acc_times_ten;
                        found_next = 1'b1;
                        idx_next   = idx_reg + IW'(1);
                    end
                end
                else if (at_end)
                begin
                    state_next      = S_DONE;
                    res_next.answer = 16'hFFFF;
                end
                else if (c_hit && idx_reg == COLON_LAST)
                begin
                    digits_next = 1'b1;
                    idx_next    = idx_reg + IW'(1);
                end
                else if (g_hit && idx_reg == CHANGE_LAST)
                begin
                    state_next        = S_DONE;
                    parsed_layer_next = parsed_layer_reg + 16'd1;
                    res_next.answer   = parsed_layer_reg + 16'd1;
                end
                else if (!c_hit && !g_hit)
                begin
                    state_next      = S_DONE;
                    res_next.answer = 16'hFFFF;
                end
                else
                begin
                    colon_ok_next  = c_hit;
                    change_ok_next = g_hit;
                    idx_next       = idx_reg + IW'(1);
                end
                res_next.feed_percent = feed_register_reg;
                res_next.fan_write    = 1'b0;
                res_next.fan_value    = '0;
                res_next.early_active = early_flag_reg;
            end

            S_DONE:
            begin
                // Hand the result to the output register when it is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Enter or leave the early layers
        if (apply_en && print_active_reg)
        begin
            if (!feature_enable_reg)
            begin
                if (early_flag_reg)
                begin
                    early_flag_next    = 1'b0;
                    feed_register_next = FEED_FULL;
                    fan_wr             = 1'b1;
                    fan_val            = saved_fan_reg;
                end
            end
            else if (apply_early)
            begin
                early_flag_next    = 1'b1;
                feed_register_next = early_feed_percent_reg;
                fan_wr             = 1'b1;
                fan_val            = early_fan_speed_reg;
            end
            else if (early_flag_reg)
            begin
                early_flag_next    = 1'b0;
                feed_register_next = FEED_FULL;
                fan_wr             = 1'b1;
                fan_val            = saved_fan_reg;
            end
        end

        // Capture the result of a one-step event
        if (load_simple)
        begin
            res_next.feed_percent = feed_register_next;
            res_next.fan_write    = fan_wr;
            res_next.fan_value    = fan_val;
            res_next.early_active = early_flag_next;
            res_next.answer       = answer;
        end
    end

    // Hold state, configuration and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg              <= S_IDLE;
            feature_enable_reg     <= FEATURE_ENABLE_RESET;
            early_layer_count_reg  <= EARLY_LAYER_COUNT_RESET;
            early_feed_percent_reg <= EARLY_FEED_PERCENT_RESET;
            early_fan_speed_reg    <= EARLY_FAN_SPEED_RESET;
            z_step_threshold_reg   <= Z_STEP_THRESHOLD_RESET;
            print_active_reg       <= 1'b0;
            early_flag_reg         <= 1'b0;
            marker_seen_reg        <= 1'b0;
            have_z_reg             <= 1'b0;
            tracked_layer_reg      <= 16'hFFFF;
            parsed_layer_reg       <= 16'hFFFF;
            comment_len_reg        <= '0;
            saved_fan_reg          <= '0;
            last_z_reg             <= '0;
            feed_register_reg      <= FEED_FULL;
            idx_reg                <= '0;
            acc_reg                <= '0;
            found_reg              <= 1'b0;
            digits_reg             <= 1'b0;
            colon_ok_reg           <= 1'b0;
            change_ok_reg          <= 1'b0;
            res_reg                <= '0;
            out_reg                <= '0;
            out_valid_reg          <= 1'b0;
        end
        else
        begin
            state_reg              <= state_next;
            feature_enable_reg     <= feature_enable_next;
            early_layer_count_reg  <= early_layer_count_next;
            early_feed_percent_reg <= early_feed_percent_next;
            early_fan_speed_reg    <= early_fan_speed_next;
            z_step_threshold_reg   <= z_step_threshold_next;
            print_active_reg       <= print_active_next;
            early_flag_reg         <= early_flag_next;
            marker_seen_reg        <= marker_seen_next;
            have_z_reg             <= have_z_next;
            tracked_layer_reg      <= tracked_layer_next;
            parsed_layer_reg       <= parsed_layer_next;
            comment_len_reg        <= comment_len_next;
            saved_fan_reg          <= saved_fan_next;
            last_z_reg             <= last_z_next;
            feed_register_reg      <= feed_register_next;
            idx_reg                <= idx_next;
            acc_reg                <= acc_next;
            found_reg              <= found_next;
            digits_reg             <= digits_next;
            colon_ok_reg           <= colon_ok_next;
            change_ok_reg          <= change_ok_next;
            res_reg                <= res_next;
            out_reg                <= out_next;
            out_valid_reg          <= out_valid_next;
        end
    end

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the first-layer feed and fan override block.
`timescale 1ns / 100ps

module testbench;
    import flsfo_pkg::*;

    localparam int BUF_BYTES    = COMMENT_BYTES_DEFAULT;
    localparam int IDLE_PCT     = 27;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 150;
    localparam int DRAIN_CYCLES = 60;
    localparam int PRINT_CAP    = 40;
    localparam int PHASE_EVENTS = 240;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    in_item_t               in_data   = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    out_item_t              out_data;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // Register copies used for prediction
    logic        cf_enable       = FEATURE_ENABLE_RESET;
    logic [7:0]  cf_early_layers = EARLY_LAYER_COUNT_RESET;
    logic [9:0]  cf_early_feed   = EARLY_FEED_PERCENT_RESET;
    logic [7:0]  cf_early_fan    = EARLY_FAN_SPEED_RESET;
    logic [15:0] cf_z_step       = Z_STEP_THRESHOLD_RESET;

    // Predicted block state
    logic        job_running     = 1'b0;
    logic        override_flag   = 1'b0;
    logic        marker_mode     = 1'b0;
    logic        z_started       = 1'b0;
    logic [15:0] layer_now       = 16'hFFFF;
    logic [15:0] comment_layer   = 16'hFFFF;
    int          text_len        = 0;
    logic [7:0]  text_buf [BUF_BYTES];
    logic [7:0]  fan_restore     = 8'd0;
    logic [23:0] z_prev          = 24'd0;
    logic [9:0]  feed_now        = FEED_FULL;
    logic        fan_hit;
    logic [7:0]  fan_pwm;

    // Words waiting to be sent and results still owed by the block
    in_item_t    pending_words [$];
    out_item_t   expected_words [$];
    logic [7:0]  text_out [$];

    int          queued_events  = 0;
    int          mismatch_count = 0;
    int          words_seen     = 0;
    int          hold_left      = 0;
    bit          hold_done      = 1'b0;
    bit          steady         = 1'b0;
    bit          in_fired       = 1'b0;
    out_item_t   due_word;

    first_layer_speed_fan_override dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Free-running clock
    always #5 clk = ~clk;

    // Report one wrong field and count it
    task automatic flag_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("MISMATCH %s: got %0d expected %0d at %0t ns", what, got, want, $time);
    endtask

    // Twelve-letter tag that steps the parsed layer by one
    function automatic string step_tag();
        return {"LAYER_", "CHANGE"};
    endfunction

    // Leave the early layers: full feed, fan back to the requested speed
    function automatic void restore_full();
        override_flag = 1'b0;
        feed_now      = FEED_FULL;
        fan_hit       = 1'b1;
        fan_pwm       = fan_restore;
    endfunction

    // Apply a new layer number to the override
    function automatic void enter_layer(input logic [15:0] layer_bits);
        if (!job_running)
            return;
        if (!cf_enable)
        begin
            if (override_flag)
                restore_full();
            return;
        end
        if (int'($signed(layer_bits)) < int'(cf_early_layers))
        begin
            override_flag = 1'b1;
            feed_now      = cf_early_feed;
            fan_hit       = 1'b1;
            fan_pwm       = cf_early_fan;
        end
        else if (override_flag)
        begin
            restore_full();
        end
    endfunction

    // Check the comment text for a fixed prefix
    function automatic bit text_starts(input string pat);
        int i;
        if (text_len < pat.len())
            return 1'b0;
        for (i = 0; i < pat.len(); i++)
            if (text_buf[i] != pat[i])
                return 1'b0;
        return 1'b1;
    endfunction

    // Decode the buffered comment into a layer number, or all ones
    function automatic logic [15:0] read_layer_tag();
        logic [15:0] acc;
        bit          got;
        int          i;
        acc = 16'd0;
        got = 1'b0;
        if (text_starts("LAYER:"))
        begin
            for (i = 6; i < text_len; i++)
            begin
                if (text_buf[i] < "0" || text_buf[i] > "9")
                    break;
                got = 1'b1;
                acc = acc * 16'd10 + {8'd0, text_buf[i] - 8'h30};
            end
            if (got)
            begin
                comment_layer = acc;
                return acc;
            end
        end
        else if (text_starts(step_tag()))
        begin
            comment_layer = comment_layer + 16'd1;
            return comment_layer;
        end
        return 16'hFFFF;
    endfunction

    // Work out the result of one accepted word and advance the state
    function automatic out_item_t predict_word(input in_item_t w);
        out_item_t   r;
        logic        held;
        logic [15:0] ans;
        logic [7:0]  req_pwm;
        fan_hit = 1'b0;
        fan_pwm = 8'd0;
        ans     = 16'd0;
        held    = job_running && cf_enable && override_flag;
        req_pwm = (w.request_value > 10'd255) ? 8'hFF : w.request_value[7:0];
        case (w.operation)
            OP_START:
            begin
                if (!job_running)
                begin
                    job_running   = 1'b1;
                    override_flag = 1'b0;
                    marker_mode   = 1'b0;
                    z_started     = 1'b0;
                    layer_now     = 16'hFFFF;
                    comment_layer = 16'hFFFF;
                    text_len      = 0;
                    fan_restore   = req_pwm;
                end
            end
            OP_END:
            begin
                if (override_flag)
                begin
                    fan_hit = 1'b1;
                    fan_pwm = fan_restore;
                end
                feed_now      = FEED_FULL;
                job_running   = 1'b0;
                override_flag = 1'b0;
            end
            OP_COMMENT_BEGIN: text_len = 0;
            OP_COMMENT_BYTE:
            begin
                if (text_len < BUF_BYTES - 1)
                begin
                    text_buf[text_len] = w.char_code;
                    text_len++;
                end
            end
            OP_COMMENT_END: ans = read_layer_tag();
            OP_LAYER_MARKER:
            begin
                marker_mode = 1'b1;
                layer_now   = w.layer_value;
                enter_layer(w.layer_value);
            end
            OP_EXTRUSION:
            begin
                if (job_running && !marker_mode)
                begin
                    if (!z_started)
                    begin
                        z_started = 1'b1;
                        z_prev    = w.z_height;
                        layer_now = 16'd0;
                        enter_layer(16'd0);
                    end
                    else if (32'(w.z_height) > 32'(z_prev) + 32'(cf_z_step))
                    begin
                        z_prev    = w.z_height;
                        layer_now = layer_now + 16'd1;
                        enter_layer(layer_now);
                    end
                end
            end
            OP_FAN_REQUEST:
            begin
                if (job_running && w.fan_index == 3'd0)
                    fan_restore = req_pwm;
                ans = (held && w.fan_index == 3'd0) ? {8'd0, cf_early_fan} : {8'd0, req_pwm};
            end
            OP_SPEED_REQUEST: ans = held ? {6'd0, cf_early_feed} : {6'd0, w.request_value};
            default: ;
        endcase
        r.feed_percent = feed_now;
        r.fan_write    = fan_hit;
        r.fan_value    = fan_hit ? fan_pwm : 8'd0;
        r.early_active = override_flag;
        r.answer       = ans;
        return r;
    endfunction

    // Predict on input acceptance, check on output acceptance
    always @(posedge clk)
    begin
        in_fired = 1'b0;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                expected_words.push_back(predict_word(in_data));
                pending_words.delete(0);
                in_fired = 1'b1;
            end
            if (out_valid && !out_stall)
            begin
                words_seen++;
                if (expected_words.size() == 0)
                begin
                    flag_mismatch("unexpected word", out_data.answer, 0);
                end
                else
                begin
                    due_word = expected_words.pop_front();
                    if (out_data.feed_percent !== due_word.feed_percent)
                        flag_mismatch("feed_percent", out_data.feed_percent,
                                      due_word.feed_percent);
                    if (out_data.fan_write !== due_word.fan_write)
                        flag_mismatch("fan_write", out_data.fan_write, due_word.fan_write);
                    if (out_data.fan_value !== due_word.fan_value)
                        flag_mismatch("fan_value", out_data.fan_value, due_word.fan_value);
                    if (out_data.early_active !== due_word.early_active)
                        flag_mismatch("early_active", out_data.early_active,
                                      due_word.early_active);
                    if (out_data.answer !== due_word.answer)
                        flag_mismatch("answer", $signed(out_data.answer),
                                      $signed(due_word.answer));
                end
            end
        end
    end

    // Drive input words; hold a stalled word, idle at random
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_fired)
        begin
            if (pending_words.size() > 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT))
            begin
                in_valid <= 1'b1;
                in_data  <= pending_words[0];
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Stall the output at random, once for a long stretch
    always @(negedge clk)
    begin
        if (!hold_done && words_seen >= HOLD_AFTER)
        begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Random word with a given operation
    function automatic in_item_t word_of(input logic [3:0] op);
        in_item_t w;
        w.operation     = op;
        w.char_code     = 8'($urandom);
        w.layer_value   = 16'($urandom);
        w.z_height      = 24'($urandom);
        w.fan_index     = 3'($urandom);
        w.request_value = 10'($urandom_range(0, 999));
        return w;
    endfunction

    function automatic void send(input in_item_t w);
        pending_words.push_back(w);
        queued_events++;
    endfunction

    function automatic void add_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            text_out.push_back(s[i]);
    endfunction

    // Queue one comment: layer tags, near misses, noise and overflow
    function automatic void send_comment();
        int         kind;
        int         i;
        int         pos;
        logic [7:0] ch;
        in_item_t   w;
        text_out.delete();
        kind = $urandom_range(0, 7);
        case (kind)
            0: add_text($sformatf("LAYER:%0d", $urandom_range(0, 300)));
            1: add_text($sformatf("LAYER:%0d", $urandom_range(0, 99999)));
            2: add_text(step_tag());
            3:
            begin
                if ($urandom_range(0, 1) != 0)
                    add_text("LAYER:");
                else
                    add_text("LAYER:x5");
            end
            4:
            begin
                if ($urandom_range(0, 1) != 0)
                    add_text("LAYER:12");
                else
                    add_text(step_tag());
                pos = $urandom_range(0, text_out.size() - 1);
                ch  = ($urandom_range(0, 1) != 0) ? 8'h00 : 8'($urandom_range(0, 255));
                text_out[pos] = ch;
            end
            5:
            begin
                for (i = $urandom_range(0, 40); i > 0; i--)
                    text_out.push_back(8'($urandom_range(0, 255)));
            end
            6:
            begin
                add_text("LAYER:");
                for (i = 0; i < 30; i++)
                    text_out.push_back(8'($urandom_range(48, 57)));
            end
            default:
            begin
                add_text("LAYER:3");
                text_out.push_back(8'h00);
                add_text("7");
            end
        endcase
        if ($urandom_range(0, 2) == 0)
            add_text(" ;layer");
        // now and then append to the previous comment
        if ($urandom_range(0, 9) != 0)
            send(word_of(OP_COMMENT_BEGIN));
        for (i = 0; i < text_out.size(); i++)
        begin
            w = word_of(OP_COMMENT_BYTE);
            w.char_code = text_out[i];
            send(w);
        end
        send(word_of(OP_COMMENT_END));
        if ($urandom_range(0, 7) == 0)
            send(word_of(OP_COMMENT_END));
    endfunction

    // Events that fall between layer changes
    function automatic void send_body_event(input logic [23:0] z_now);
        in_item_t w;
        case ($urandom_range(0, 4))
            0:
            begin
                w = word_of(OP_FAN_REQUEST);
                if ($urandom_range(0, 3) != 0)
                    w.fan_index = 3'd0;
                send(w);
            end
            1: send(word_of(OP_SPEED_REQUEST));
            2:
            begin
                w = word_of(OP_EXTRUSION);
                w.z_height = z_now;
                send(w);
            end
            3: send_comment();
            default: send(word_of(4'($urandom_range(9, 15))));
        endcase
    endfunction

    // One print job: start, several layers by Z, markers or tags, then end
    function automatic void send_job();
        int          layers;
        int          k;
        int          style;
        logic [15:0] n;
        logic [31:0] z_rise;
        logic [23:0] z;
        in_item_t    w;
        layers = $urandom_range(1, 6);
        style  = $urandom_range(0, 2);
        w = word_of(OP_START);
        if ($urandom_range(0, 3) == 0)
            w.request_value = 10'($urandom_range(256, 999));
        send(w);
        z = 24'($urandom_range(0, 400));
        for (k = 0; k < layers; k++)
        begin
            if (style == 0)
            begin
                w = word_of(OP_EXTRUSION);
                w.z_height = z;
                send(w);
                case ($urandom_range(0, 3))
                    0:       z_rise = 32'(cf_z_step);
                    1:       z_rise = cf_z_step + 1;
                    2:       z_rise = $urandom_range(0, cf_z_step);
                    default: z_rise = cf_z_step + $urandom_range(1, 400);
                endcase
                z = z + z_rise[23:0];
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0:       n = 16'($urandom);
                    1, 2:    n = 16'($urandom_range(0, cf_early_layers + 2));
                    default: n = 16'(k);
                endcase
                if (style == 2)
                begin
                    text_out.delete();
                    send(word_of(OP_COMMENT_BEGIN));
                    add_text($sformatf("LAYER:%0d", n));
                    for (int i = 0; i < text_out.size(); i++)
                    begin
                        w = word_of(OP_COMMENT_BYTE);
                        w.char_code = text_out[i];
                        send(w);
                    end
                    send(word_of(OP_COMMENT_END));
                end
                w = word_of(OP_LAYER_MARKER);
                w.layer_value = n;
                send(w);
            end
            repeat ($urandom_range(0, 4))
                send_body_event(z);
        end
        // sometimes leave the job running so the next start is a resume
        if ($urandom_range(0, 9) != 0)
            send(word_of(OP_END));
        if ($urandom_range(0, 9) == 0)
            send(word_of(OP_END));
    endfunction

    // Random traffic for one configuration
    function automatic void fill_random(input int quota);
        int r;
        queued_events = 0;
        while (queued_events < quota)
        begin
            r = $urandom_range(0, 99);
            if (r < 75)
                send_job();
            else if (r < 90)
                send_comment();
            else
                repeat ($urandom_range(1, 5))
                    send(word_of(4'($urandom_range(0, 15))));
        end
    endfunction

    // Fixed word list: field extremes, every operation but comment byte, corner cases
    function automatic void send_directed();
        in_item_t w;
        w = word_of(OP_FAN_REQUEST);   w.fan_index = 3'd0; w.request_value = 10'd200; send(w);
        w = word_of(OP_START);         w.request_value = 10'd999; send(w);
        w = word_of(OP_START);         w.request_value = 10'd0;   send(w);
        w = word_of(OP_EXTRUSION);     w.z_height = 24'd0;        send(w);
        w = word_of(OP_FAN_REQUEST);   w.fan_index = 3'd0; w.request_value = 10'd999; send(w);
        w = word_of(OP_FAN_REQUEST);   w.fan_index = 3'd7; w.request_value = 10'd300; send(w);
        w = word_of(OP_SPEED_REQUEST); w.request_value = 10'd999; send(w);
        w = word_of(OP_EXTRUSION);     w.z_height = 24'd50;       send(w);
        w = word_of(OP_EXTRUSION);     w.z_height = 24'd51;       send(w);
        w = word_of(OP_EXTRUSION);     w.z_height = 24'hFFFFFF;   send(w);
        w = word_of(OP_LAYER_MARKER);  w.layer_value = 16'h8000;  send(w);
        w = word_of(OP_LAYER_MARKER);  w.layer_value = 16'sd32767; send(w);
        send(word_of(OP_COMMENT_BEGIN));
        send(word_of(OP_COMMENT_END));
        send(word_of(4'd9));
        send(word_of(4'd15));
        send(word_of(OP_END));
        send(word_of(OP_END));
        w = word_of(OP_LAYER_MARKER);  w.layer_value = 16'sd0;    send(w);
        w = word_of(OP_SPEED_REQUEST); w.request_value = 10'd0;   send(w);
        w = word_of(OP_EXTRUSION);     w.z_height = 24'd1000;     send(w);
    endfunction

    // Wait until every queued word has been sent and answered
    task automatic wait_drained();
        while (pending_words.size() != 0 || expected_words.size() != 0)
            @(posedge clk);
    endtask

    task automatic put_reg(input cfg_reg_t idx, input logic [15:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
    endtask

    // Write all registers back to back while the block is idle
    task automatic program_regs(input logic en, input logic [7:0] layers,
                                input logic [9:0] feed, input logic [7:0] fan,
                                input logic [15:0] z_step);
        put_reg(REG_FEATURE_ENABLE,     {15'd0, en});
        put_reg(REG_EARLY_LAYER_COUNT,  {8'd0, layers});
        put_reg(REG_EARLY_FEED_PERCENT, {6'd0, feed});
        put_reg(REG_EARLY_FAN_SPEED,    {8'd0, fan});
        put_reg(REG_Z_STEP_THRESHOLD,   z_step);
        @(negedge clk);
        cfg_we          <= 1'b0;
        cf_enable       = en;
        cf_early_layers = layers;
        cf_early_feed   = feed;
        cf_early_fan    = fan;
        cf_z_step       = z_step;
    endtask

    // Reset, then run through several register settings
    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_directed();
        fill_random(PHASE_EVENTS);
        wait_drained();

        program_regs(1'b1, 8'd255, 10'd999, 8'd255, 16'd1);
        fill_random(PHASE_EVENTS);
        wait_drained();

        // no idling on either side in this stretch
        steady = 1'b1;
        program_regs(1'b0, 8'd4, 10'd10, 8'd128, 16'd50);
        fill_random(PHASE_EVENTS);
        wait_drained();
        steady = 1'b0;

        program_regs(1'b1, 8'd0, 10'd10, 8'd0, 16'd65535);
        fill_random(PHASE_EVENTS);
        wait_drained();

        program_regs(1'b1, 8'd3, 10'($urandom_range(10, 999)), 8'($urandom_range(0, 255)),
                     16'($urandom_range(20, 300)));
        fill_random(PHASE_EVENTS);
        wait_drained();

        program_regs(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                     10'($urandom_range(10, 999)), 8'($urandom_range(0, 255)),
                     16'($urandom_range(1, 65535)));
        fill_random(PHASE_EVENTS);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_words.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Give up on a hung run
    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ----- first_layer_speed_fan_override.f -----
rtl/core/flsfo_pkg.sv
rtl/core/flsfo_ram.sv
rtl/core/first_layer_speed_fan_override.sv
dv/testbench.sv
